@@ sv/avc_config_record_parser_assert.svh @@
`ifndef AVC_CONFIG_RECORD_PARSER_ASSERT_SVH
`define AVC_CONFIG_RECORD_PARSER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ACRP_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ACRP_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ sv/acrp_pkg.sv @@
`default_nettype none

package acrp_pkg;

   // Parser phases, one-hot
   typedef enum logic [8:0] {
      PH_HEADER   = 9'b000000001,
      PH_SPS_LENH = 9'b000000010,
      PH_SPS_LENL = 9'b000000100,
      PH_SPS_DATA = 9'b000001000,
      PH_PPS_CNT  = 9'b000010000,
      PH_PPS_LENH = 9'b000100000,
      PH_PPS_LENL = 9'b001000000,
      PH_PPS_DATA = 9'b010000000,
      PH_TRAIL    = 9'b100000000
   } phase_type;

   // Byte tags
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_SPS    = 2'd1;
   localparam logic [1:0] KIND_PPS    = 2'd2;
   localparam logic [1:0] KIND_TRAIL  = 2'd3;

   // End-of-record status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_SHORT_HDR  = 3'd1;
   localparam logic [2:0] ST_SPS_LEN    = 3'd2;
   localparam logic [2:0] ST_SPS_DATA   = 3'd3;
   localparam logic [2:0] ST_PPS_CNT    = 3'd4;
   localparam logic [2:0] ST_PPS_LEN    = 3'd5;
   localparam logic [2:0] ST_PPS_DATA   = 3'd6;
   localparam logic [2:0] ST_NO_ENTRIES = 3'd7;

   // Header layout
   localparam logic [2:0] POS_PROFILE  = 3'd1;
   localparam logic [2:0] POS_COMPAT   = 3'd2;
   localparam logic [2:0] POS_LEVEL    = 3'd3;
   localparam logic [2:0] POS_LEN_SIZE = 3'd4;
   localparam logic [2:0] POS_SPS_CNT  = 3'd5;

   localparam logic [7:0] LEN_SIZE_MASK  = 8'h03;
   localparam logic [7:0] SPS_COUNT_MASK = 8'h1F;

endpackage

`default_nettype wire

@@ sv/acrp_if.sv @@
`default_nettype none

interface acrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface acrp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] byte_kind;
   logic [7:0] entry_index;
   logic [7:0] byte_out;
   logic       record_done;
   logic [2:0] status;
   logic [7:0] profile;
   logic [7:0] profile_compat;
   logic [7:0] level;
   logic [2:0] nal_length_size;
   logic [4:0] sps_found;
   logic [7:0] pps_found;

   modport source (
      output valid, input ready,
      output byte_kind, output entry_index, output byte_out, output record_done,
      output status, output profile, output profile_compat, output level,
      output nal_length_size, output sps_found, output pps_found
   );
   modport sink (
      input valid, output ready,
      input byte_kind, input entry_index, input byte_out, input record_done,
      input status, input profile, input profile_compat, input level,
      input nal_length_size, input sps_found, input pps_found
   );
endinterface

`default_nettype wire

@@ sv/avc_config_record_parser.sv @@
// AVC decoder configuration record parser.
// req_bus carries the record one byte per beat; last_byte marks its final byte.
// rsp_bus returns one beat per input byte: the byte passed through, its tag
// (header/length, SPS payload, PPS payload, trailing) with the entry index,
// the header fields captured so far and the counts of completed entries.
// On the beat with record_done set, status tells whether the record was whole
// or where it was cut; the parser then starts over for the next record.
// A result beat appears in the cycle after its byte is accepted. Throughput
// is one byte per cycle while rsp_bus takes its beats: the parse state and
// the result register are both updated in the cycle a byte is accepted.
// The result register frees itself in the same cycle its beat is taken, so
// req_bus.ready stays high while rsp_bus is flowing. When the receiver stalls
// with a result pending, req_bus.ready drops and the parser holds its state.
// Synchronous reset returns the parser to the start of a record, clears all
// captured header values and counts, and empties the result register.
`default_nettype none

`include "avc_config_record_parser_assert.svh"

module avc_config_record_parser (
   input  logic       clock,
   input  logic       reset,
   acrp_req_if.sink   req_bus,
   acrp_rsp_if.source rsp_bus
);
   import acrp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  byte_position_ff, byte_position_in;
   logic [7:0]  entries_left_ff, entries_left_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [7:0]  current_entry_ff, current_entry_in;
   logic [4:0]  sps_total_ff, sps_total_in;
   logic [7:0]  pps_total_ff, pps_total_in;
   logic [7:0]  profile_ff, profile_in;
   logic [7:0]  compat_ff, compat_in;
   logic [7:0]  level_ff, level_in;
   logic [1:0]  length_size_ff, length_size_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  index_ff, index_in;
   logic [7:0]  byte_ff;
   logic        done_ff;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  out_profile_ff, out_profile_in;
   logic [7:0]  out_compat_ff, out_compat_in;
   logic [7:0]  out_level_ff, out_level_in;
   logic [2:0]  out_nls_ff, out_nls_in;
   logic [4:0]  out_sps_ff, out_sps_in;
   logic [7:0]  out_pps_ff, out_pps_in;

   logic req_fire;
   logic finish;
   logic finish_sps;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      phase_in         = phase_ff;
      byte_position_in = byte_position_ff;
      entries_left_in  = entries_left_ff;
      bytes_left_in    = bytes_left_ff;
      length_high_in   = length_high_ff;
      current_entry_in = current_entry_ff;
      sps_total_in     = sps_total_ff;
      pps_total_in     = pps_total_ff;
      profile_in       = profile_ff;
      compat_in        = compat_ff;
      level_in         = level_ff;
      length_size_in   = length_size_ff;
      kind_in          = KIND_HEADER;
      index_in         = 8'd0;
      status_in        = ST_OK;
      finish           = 1'b0;
      finish_sps       = 1'b0;

      unique case (phase_ff)
         PH_HEADER: begin
            unique case (byte_position_ff)
               POS_PROFILE:  profile_in     = req_bus.data_byte;
               POS_COMPAT:   compat_in      = req_bus.data_byte;
               POS_LEVEL:    level_in       = req_bus.data_byte;
               POS_LEN_SIZE: length_size_in = req_bus.data_byte[1:0] & LEN_SIZE_MASK[1:0];
               POS_SPS_CNT: begin
                  entries_left_in  = req_bus.data_byte & SPS_COUNT_MASK;
                  current_entry_in = 8'd0;
                  phase_in = ((req_bus.data_byte & SPS_COUNT_MASK) == 8'd0) ?
                             PH_PPS_CNT : PH_SPS_LENH;
               end
               default: ;
            endcase
            byte_position_in = byte_position_ff + 3'd1;
         end
         PH_SPS_LENH, PH_PPS_LENH: begin
            index_in       = current_entry_ff;
            length_high_in = req_bus.data_byte;
            phase_in       = (phase_ff == PH_SPS_LENH) ? PH_SPS_LENL : PH_PPS_LENL;
         end
         PH_SPS_LENL, PH_PPS_LENL: begin
            index_in      = current_entry_ff;
            bytes_left_in = {length_high_ff, req_bus.data_byte};
            if ({length_high_ff, req_bus.data_byte} == 16'd0) begin
               finish     = 1'b1;
               finish_sps = (phase_ff == PH_SPS_LENL);
            end else begin
               phase_in = (phase_ff == PH_SPS_LENL) ? PH_SPS_DATA : PH_PPS_DATA;
            end
         end
         PH_SPS_DATA, PH_PPS_DATA: begin
            kind_in       = (phase_ff == PH_SPS_DATA) ? KIND_SPS : KIND_PPS;
            index_in      = current_entry_ff;
            bytes_left_in = bytes_left_ff - 16'd1;
            if (bytes_left_ff == 16'd1) begin
               finish     = 1'b1;
               finish_sps = (phase_ff == PH_SPS_DATA);
            end
         end
         PH_PPS_CNT: begin
            entries_left_in  = req_bus.data_byte;
            current_entry_in = 8'd0;
            phase_in = (req_bus.data_byte == 8'd0) ? PH_TRAIL : PH_PPS_LENH;
         end
         PH_TRAIL: begin
            kind_in = KIND_TRAIL;
         end
         default: begin
            kind_in  = KIND_TRAIL;
            phase_in = PH_TRAIL;
         end
      endcase

      // close the current entry and step to the next one or past the end of its list
      if (finish) begin
         if (finish_sps) begin
            sps_total_in = sps_total_ff + 5'd1;
         end else begin
            pps_total_in = pps_total_ff + 8'd1;
         end
         current_entry_in = current_entry_ff + 8'd1;
         entries_left_in  = entries_left_ff - 8'd1;
         if (entries_left_ff == 8'd1) begin
            phase_in = finish_sps ? PH_PPS_CNT : PH_TRAIL;
         end else begin
            phase_in = finish_sps ? PH_SPS_LENH : PH_PPS_LENH;
         end
      end

      if (req_bus.last_byte) begin
         unique case (phase_in)
            PH_HEADER:                status_in = ST_SHORT_HDR;
            PH_SPS_LENH, PH_SPS_LENL: status_in = ST_SPS_LEN;
            PH_SPS_DATA:              status_in = ST_SPS_DATA;
            PH_PPS_CNT:               status_in = ST_PPS_CNT;
            PH_PPS_LENH, PH_PPS_LENL: status_in = ST_PPS_LEN;
            PH_PPS_DATA:              status_in = ST_PPS_DATA;
            default: status_in = (sps_total_in == 5'd0 || pps_total_in == 8'd0) ?
                                 ST_NO_ENTRIES : ST_OK;
         endcase
      end

      // results show the state after this byte, before the end-of-record clear
      out_profile_in = profile_in;
      out_compat_in  = compat_in;
      out_level_in   = level_in;
      out_nls_in     = {1'b0, length_size_in} + 3'd1;
      out_sps_in     = sps_total_in;
      out_pps_in     = pps_total_in;

      if (req_bus.last_byte) begin
         phase_in         = PH_HEADER;
         byte_position_in = 3'd0;
         entries_left_in  = 8'd0;
         bytes_left_in    = 16'd0;
         length_high_in   = 8'd0;
         current_entry_in = 8'd0;
         sps_total_in     = 5'd0;
         pps_total_in     = 8'd0;
         profile_in       = 8'd0;
         compat_in        = 8'd0;
         level_in         = 8'd0;
         length_size_in   = 2'd0;
      end
   end

   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         byte_position_ff <= 3'd0;
         entries_left_ff  <= 8'd0;
         bytes_left_ff    <= 16'd0;
         length_high_ff   <= 8'd0;
         current_entry_ff <= 8'd0;
         sps_total_ff     <= 5'd0;
         pps_total_ff     <= 8'd0;
         profile_ff       <= 8'd0;
         compat_ff        <= 8'd0;
         level_ff         <= 8'd0;
         length_size_ff   <= 2'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff         <= phase_in;
            byte_position_ff <= byte_position_in;
            entries_left_ff  <= entries_left_in;
            bytes_left_ff    <= bytes_left_in;
            length_high_ff   <= length_high_in;
            current_entry_ff <= current_entry_in;
            sps_total_ff     <= sps_total_in;
            pps_total_ff     <= pps_total_in;
            profile_ff       <= profile_in;
            compat_ff        <= compat_in;
            level_ff         <= level_in;
            length_size_ff   <= length_size_in;
         end
      end
   end

   // result payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff        <= kind_in;
         index_ff       <= index_in;
         byte_ff        <= req_bus.data_byte;
         done_ff        <= req_bus.last_byte;
         status_ff      <= status_in;
         out_profile_ff <= out_profile_in;
         out_compat_ff  <= out_compat_in;
         out_level_ff   <= out_level_in;
         out_nls_ff     <= out_nls_in;
         out_sps_ff     <= out_sps_in;
         out_pps_ff     <= out_pps_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.byte_kind       = kind_ff;
   assign rsp_bus.entry_index     = index_ff;
   assign rsp_bus.byte_out        = byte_ff;
   assign rsp_bus.record_done     = done_ff;
   assign rsp_bus.status          = status_ff;
   assign rsp_bus.profile         = out_profile_ff;
   assign rsp_bus.profile_compat  = out_compat_ff;
   assign rsp_bus.level           = out_level_ff;
   assign rsp_bus.nal_length_size = out_nls_ff;
   assign rsp_bus.sps_found       = out_sps_ff;
   assign rsp_bus.pps_found       = out_pps_ff;

   `ACRP_ASSERT_NEXT(a_restart_after_last, req_fire && req_bus.last_byte,
      phase_ff == PH_HEADER && byte_position_ff == 3'd0 && sps_total_ff == 5'd0,
      "parser did not restart after last byte")
   `ACRP_ASSERT_NOW(a_status_only_on_done, rsp_valid_ff && !done_ff,
      status_ff == ST_OK, "status set on a beat that does not end the record")
   `ACRP_ASSERT_NEXT(a_trail_tag, req_fire && phase_ff == PH_TRAIL,
      rsp_valid_ff && kind_ff == KIND_TRAIL, "trailing byte not tagged as trailing")
   `ACRP_ASSERT_NOW(a_stall_blocks_input, rsp_valid_ff && !rsp_bus.ready,
      !req_bus.ready, "input taken while a result is stalled")

endmodule

`default_nettype wire

@@ test/avc_config_record_parser_tb.sv @@
`timescale 1ns / 100ps

module avc_config_record_parser_tb;
   import acrp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [1:0] byte_kind;
      logic [7:0] entry_index;
      logic [7:0] byte_out;
      logic       record_done;
      logic [2:0] status;
      logic [7:0] profile;
      logic [7:0] profile_compat;
      logic [7:0] level;
      logic [2:0] nal_length_size;
      logic [4:0] sps_found;
      logic [7:0] pps_found;
   } rsp_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   acrp_req_if req_bus ();
   acrp_rsp_if rsp_bus ();

   avc_config_record_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #1 clock = ~clock;

   // Parser state as the predictor sees it
   phase_type   rec_phase;
   logic [2:0]  hdr_pos;
   logic [7:0]  entries_to_go;
   logic [15:0] payload_left;
   logic [7:0]  len_high;
   logic [7:0]  entry_no;
   logic [4:0]  sps_done;
   logic [7:0]  pps_done;
   logic [7:0]  cap_profile;
   logic [7:0]  cap_compat;
   logic [7:0]  cap_level;
   logic [1:0]  cap_len_size;

   rsp_beat_type expected_beats[$];
   logic [7:0]  record_buf[$];
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   function automatic void clear_parser();
      rec_phase     = PH_HEADER;
      hdr_pos       = '0;
      entries_to_go = '0;
      payload_left  = '0;
      len_high      = '0;
      entry_no      = '0;
      sps_done      = '0;
      pps_done      = '0;
      cap_profile   = '0;
      cap_compat    = '0;
      cap_level     = '0;
      cap_len_size  = '0;
   endfunction

   function automatic void close_entry(input bit is_sps);
      if (is_sps) sps_done = sps_done + 5'd1;
      else pps_done = pps_done + 8'd1;
      entry_no = entry_no + 8'd1;
      entries_to_go = entries_to_go - 8'd1;
      if (entries_to_go == 8'd0) rec_phase = is_sps ? PH_PPS_CNT : PH_TRAIL;
      else rec_phase = is_sps ? PH_SPS_LENH : PH_PPS_LENH;
   endfunction

   // Advance the parser by one byte and queue the beat it should produce
   function automatic void parse_byte(input logic [7:0] b, input logic last);
      rsp_beat_type e;
      e = '0;
      e.byte_kind = KIND_HEADER;
      case (rec_phase)
         PH_HEADER: begin
            case (hdr_pos)
               POS_PROFILE:  cap_profile = b;
               POS_COMPAT:   cap_compat = b;
               POS_LEVEL:    cap_level = b;
               POS_LEN_SIZE: cap_len_size = b[1:0] & LEN_SIZE_MASK[1:0];
               POS_SPS_CNT: begin
                  entries_to_go = b & SPS_COUNT_MASK;
                  entry_no = '0;
                  rec_phase = (entries_to_go == 8'd0) ? PH_PPS_CNT : PH_SPS_LENH;
               end
               default: ;
            endcase
            hdr_pos = hdr_pos + 3'd1;
         end
         PH_SPS_LENH, PH_PPS_LENH: begin
            e.entry_index = entry_no;
            len_high = b;
            rec_phase = (rec_phase == PH_SPS_LENH) ? PH_SPS_LENL : PH_PPS_LENL;
         end
         PH_SPS_LENL, PH_PPS_LENL: begin
            e.entry_index = entry_no;
            payload_left = {len_high, b};
            if (payload_left == 16'd0) close_entry(rec_phase == PH_SPS_LENL);
            else rec_phase = (rec_phase == PH_SPS_LENL) ? PH_SPS_DATA : PH_PPS_DATA;
         end
         PH_SPS_DATA, PH_PPS_DATA: begin
            e.byte_kind = (rec_phase == PH_SPS_DATA) ? KIND_SPS : KIND_PPS;
            e.entry_index = entry_no;
            payload_left = payload_left - 16'd1;
            if (payload_left == 16'd0) close_entry(rec_phase == PH_SPS_DATA);
         end
         PH_PPS_CNT: begin
            entries_to_go = b;
            entry_no = '0;
            rec_phase = (b == 8'd0) ? PH_TRAIL : PH_PPS_LENH;
         end
         default: begin
            e.byte_kind = KIND_TRAIL;
            rec_phase = PH_TRAIL;
         end
      endcase

      e.status = ST_OK;
      if (last) begin
         case (rec_phase)
            PH_HEADER:                e.status = ST_SHORT_HDR;
            PH_SPS_LENH, PH_SPS_LENL: e.status = ST_SPS_LEN;
            PH_SPS_DATA:              e.status = ST_SPS_DATA;
            PH_PPS_CNT:               e.status = ST_PPS_CNT;
            PH_PPS_LENH, PH_PPS_LENL: e.status = ST_PPS_LEN;
            PH_PPS_DATA:              e.status = ST_PPS_DATA;
            default: e.status = (sps_done == 5'd0 || pps_done == 8'd0) ? ST_NO_ENTRIES : ST_OK;
         endcase
      end

      e.byte_out        = b;
      e.record_done     = last;
      e.profile         = cap_profile;
      e.profile_compat  = cap_compat;
      e.level           = cap_level;
      e.nal_length_size = {1'b0, cap_len_size} + 3'd1;
      e.sps_found       = sps_done;
      e.pps_found       = pps_done;
      expected_beats.push_back(e);
      if (last) clear_parser();
   endfunction

   function automatic void note_mismatch(input string what, input logic [7:0] want,
                                         input logic [7:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s: expected %0h, got %0h", what, want, got);
   endfunction

   function automatic void check_field(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) note_mismatch(what, want, got);
   endfunction

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.byte_kind       = rsp_bus.byte_kind;
         got.entry_index     = rsp_bus.entry_index;
         got.byte_out        = rsp_bus.byte_out;
         got.record_done     = rsp_bus.record_done;
         got.status          = rsp_bus.status;
         got.profile         = rsp_bus.profile;
         got.profile_compat  = rsp_bus.profile_compat;
         got.level           = rsp_bus.level;
         got.nal_length_size = rsp_bus.nal_length_size;
         got.sps_found       = rsp_bus.sps_found;
         got.pps_found       = rsp_bus.pps_found;
         if (expected_beats.size() == 0) begin
            note_mismatch("unexpected beat, byte_out", 8'h00, got.byte_out);
         end else begin
            want = expected_beats.pop_front();
            check_field("byte_kind", 8'(want.byte_kind), 8'(got.byte_kind));
            check_field("entry_index", want.entry_index, got.entry_index);
            check_field("byte_out", want.byte_out, got.byte_out);
            check_field("record_done", 8'(want.record_done), 8'(got.record_done));
            check_field("status", 8'(want.status), 8'(got.status));
            check_field("profile", want.profile, got.profile);
            check_field("profile_compat", want.profile_compat, got.profile_compat);
            check_field("level", want.level, got.level);
            check_field("nal_length_size", 8'(want.nal_length_size),
                        8'(got.nal_length_size));
            check_field("sps_found", 8'(want.sps_found), 8'(got.sps_found));
            check_field("pps_found", want.pps_found, got.pps_found);
         end
      end
   end

   always @(negedge clock) rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL avc_config_record_parser");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      parse_byte(b, last);
      @(negedge clock);
   endtask

   task automatic send_record();
      foreach (record_buf[i]) send_byte(record_buf[i], i == record_buf.size() - 1);
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Append one length-prefixed entry; returns 1 when the record is cut inside it
   function automatic bit add_entry(input int unsigned min_len, input int unsigned max_len,
                                    input int unsigned blowup_pct);
      int unsigned len;
      int unsigned n;
      if ($urandom_range(99) < blowup_pct) begin
         len = $urandom_range(65535);
         n = $urandom_range(10);
         if (n > len) n = len;
      end else begin
         len = $urandom_range(max_len, min_len);
         n = len;
      end
      record_buf.push_back(8'(len >> 8));
      record_buf.push_back(8'(len));
      repeat (n) record_buf.push_back(8'($urandom));
      return n < len;
   endfunction

   function automatic void build_record(input int unsigned sps_n, input int unsigned pps_n,
                                        input int unsigned min_len, input int unsigned max_len,
                                        input int unsigned trail_n,
                                        input int unsigned blowup_pct);
      record_buf.delete();
      repeat (5) record_buf.push_back(8'($urandom));
      record_buf.push_back({3'($urandom), 5'(sps_n)});
      repeat (sps_n) if (add_entry(min_len, max_len, blowup_pct)) return;
      record_buf.push_back(8'(pps_n));
      repeat (pps_n) if (add_entry(min_len, max_len, blowup_pct)) return;
      repeat (trail_n) record_buf.push_back(8'($urandom));
   endfunction

   task automatic test_short_header();
      record_buf = '{8'h01};
      send_record();
   endtask

   task automatic test_minimal_record();
      // reserved bits set in the length-size and SPS count bytes, one SPS, one empty PPS, one trailing byte
      record_buf = '{8'h01, 8'hFF, 8'h00, 8'hAA, 8'hFF, 8'hE1, 8'h00, 8'h01, 8'h5A,
                     8'h01, 8'h00, 8'h00, 8'h3C};
      send_record();
   endtask

   task automatic test_no_entries();
      record_buf = '{8'h01, 8'h42, 8'hC0, 8'h1E, 8'hFC, 8'hE0, 8'h00};
      send_record();
   endtask

   task automatic test_entry_limits();
      // full SPS and PPS counts, entries of zero or one byte
      build_record(31, 255, 0, 1, 2, 0);
      send_record();
   endtask

   task automatic test_long_entry();
      build_record(1, 1, 257, 280, 1, 0);
      send_record();
   endtask

   task automatic test_random_records(input int unsigned target);
      int unsigned sent;
      int unsigned pick;
      int unsigned sps_n;
      int unsigned pps_n;
      sent = 0;
      while (sent < target) begin
         pick  = $urandom_range(99);
         sps_n = ($urandom_range(9) == 0) ? $urandom_range(8) : $urandom_range(3, 1);
         pps_n = ($urandom_range(9) == 0) ? $urandom_range(8) : $urandom_range(3, 1);
         if (pick < 65) begin
            build_record(sps_n, pps_n, 0, 6, $urandom_range(3), 0);
         end else if (pick < 85) begin
            build_record(sps_n, pps_n, 0, 6, $urandom_range(3), 0);
            record_buf = record_buf[0:$urandom_range(record_buf.size() - 1)];
         end else if (pick < 93) begin
            build_record(sps_n, pps_n, 0, 6, 1, 40);
         end else begin
            record_buf.delete();
            repeat ($urandom_range(12, 1)) record_buf.push_back(8'($urandom));
         end
         send_record();
         sent += record_buf.size();
      end
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready     = 1'b0;
      clear_parser();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(0, 0);
      test_short_header();
      test_minimal_record();
      test_no_entries();
      test_entry_limits();
      test_random_records(20);
      wait_for_results();

      set_idling(86, 0);
      test_long_entry();
      test_random_records(20);
      wait_for_results();

      set_idling(0, 86);
      test_random_records(60);

      set_idling(8, 8);
      test_random_records(60);
      wait_for_results();

      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("PASS avc_config_record_parser");
      end else begin
         $display("FAIL avc_config_record_parser");
      end
      $finish;
   end

endmodule
